[design/lgsd_pkg.sv]
`default_nettype none

package lgsd_pkg;

  // fixed widths of the numerator and of the display value
  localparam int unsigned NUM_WIDTH   = 32;
  localparam int unsigned SPEED_WIDTH = 10;
  localparam int unsigned DIGIT_WIDTH = 4;

  localparam logic [NUM_WIDTH-1:0]   SPEED_CONSTANT_RESET = 32'd1296000;
  localparam logic [SPEED_WIDTH-1:0] SPEED_MAX            = 10'd999;
  localparam logic [SPEED_WIDTH-1:0] SPEED_HUNDRED        = 10'd100;
  localparam logic [SPEED_WIDTH-1:0] SPEED_TEN            = 10'd10;
  localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX            = 4'd9;
  localparam logic [7:0]             POINT_BIT            = 8'h80;

  // input operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BLOCK = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // top level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DIV   = 2'd1,
    ST_DIGIT = 2'd2,
    ST_OUT   = 2'd3
  } lgsd_state_e;

  typedef struct packed {
    logic [1:0] op;
    logic       lane;
  } in_beat_t;

  typedef struct packed {
    logic                   display_lane;
    logic [7:0]             high_segments;
    logic [7:0]             low_segments;
    logic [SPEED_WIDTH-1:0] speed_value;
  } out_beat_t;

  // digits split out of the speed value
  typedef struct packed {
    logic [DIGIT_WIDTH-1:0] hundreds;
    logic [DIGIT_WIDTH-1:0] tens;
    logic [DIGIT_WIDTH-1:0] ones;
  } digits_t;

  // seven-segment code of one decimal digit
  function automatic logic [7:0] seg_of(logic [DIGIT_WIDTH-1:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h3F;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

[design/lgsd_divider.sv]
`default_nettype none

module lgsd_divider #(
  parameter int unsigned CountWidth = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [lgsd_pkg::NUM_WIDTH-1:0] numerator_i,
  input  wire logic [CountWidth-1:0]          denominator_i,
  output logic                                done_o,
  output logic [lgsd_pkg::NUM_WIDTH-1:0]      quotient_o
);

  localparam int unsigned NumW  = lgsd_pkg::NUM_WIDTH;
  localparam int unsigned StepW = $clog2(NumW);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [StepW-1:0]      step_q, step_d;
  logic [NumW-1:0]       num_q, num_d;
  logic [CountWidth-1:0] rem_q, rem_d;
  logic [CountWidth-1:0] den_q, den_d;

  logic [CountWidth:0]   shifted;
  logic [CountWidth+1:0] diff;
  logic                  qbit;

  // one restoring step: shift in next numerator bit, trial subtract
  assign shifted = {rem_q, num_q[NumW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign qbit    = ~diff[CountWidth+1];

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = numerator_i;
      rem_d  = '0;
      den_d  = denominator_i;
    end else if (busy_q) begin
      num_d  = {num_q[NumW-2:0], qbit};
      rem_d  = qbit ? diff[CountWidth-1:0] : shifted[CountWidth-1:0];
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

`ifndef NO_ASSERTIONS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < den_q))
    else $error("divider remainder not below denominator");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a finished run");
`endif

endmodule

`default_nettype wire

[design/lgsd_digits.sv]
`default_nettype none

module lgsd_digits (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [lgsd_pkg::SPEED_WIDTH-1:0] value_i,
  output logic                                  done_o,
  output lgsd_pkg::digits_t                     digits_o
);

  localparam int unsigned SpW = lgsd_pkg::SPEED_WIDTH;
  localparam int unsigned DgW = lgsd_pkg::DIGIT_WIDTH;

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic           tens_phase_q, tens_phase_d;
  logic [SpW-1:0] val_q, val_d;
  logic [DgW-1:0] hund_q, hund_d;
  logic [DgW-1:0] tens_q, tens_d;

  logic [SpW-1:0] sub_amount;
  logic [SpW:0]   diff;
  logic           fits;

  // shared subtractor: hundreds first, then tens
  assign sub_amount = tens_phase_q ? lgsd_pkg::SPEED_TEN : lgsd_pkg::SPEED_HUNDRED;
  assign diff       = {1'b0, val_q} - {1'b0, sub_amount};
  assign fits       = ~diff[SpW];

  // step sequencing
  always_comb begin
    busy_d       = busy_q;
    done_d       = 1'b0;
    tens_phase_d = tens_phase_q;
    val_d        = val_q;
    hund_d       = hund_q;
    tens_d       = tens_q;
    if (start_i) begin
      busy_d       = 1'b1;
      tens_phase_d = 1'b0;
      val_d        = value_i;
      hund_d       = '0;
      tens_d       = '0;
    end else if (busy_q) begin
      if (fits) begin
        val_d = diff[SpW-1:0];
        if (tens_phase_q) begin
          tens_d = tens_q + DgW'(1);
        end else begin
          hund_d = hund_q + DgW'(1);
        end
      end else if (!tens_phase_q) begin
        tens_phase_d = 1'b1;
      end else begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      done_q       <= 1'b0;
      tens_phase_q <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      done_q       <= done_d;
      tens_phase_q <= tens_phase_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    hund_q <= hund_d;
    tens_q <= tens_d;
  end

  assign done_o            = done_q;
  assign digits_o.hundreds = hund_q;
  assign digits_o.tens     = tens_q;
  assign digits_o.ones     = val_q[DgW-1:0];

endmodule

`default_nettype wire

[design/light_gate_speed_display_unit.sv]
`default_nettype none

// Light gate speed display. Timer ticks and blocked edges are accepted back to back, one
// per cycle, while the sequencer is idle. A clear edge on the claiming lane that produces
// a result keeps in_stall_o high until the block is idle again, including any wait on the
// output register: the bit-serial restoring divider runs 32 steps and then signals done
// (skipped when the count is zero), the digit splitter subtracts hundreds and tens with
// one shared subtractor in up to 20 steps and then signals done, and the result is loaded
// into the output register. If the output register still holds an untaken beat, the block
// waits there before going idle. The speed constant is written through the cfg channel,
// which is always ready.
module light_gate_speed_display_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lgsd_pkg::NUM_WIDTH-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire lgsd_pkg::in_beat_t             in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output lgsd_pkg::out_beat_t                 out_data_o
);

  localparam int unsigned NumW = lgsd_pkg::NUM_WIDTH;
  localparam int unsigned SpW  = lgsd_pkg::SPEED_WIDTH;

  lgsd_pkg::lgsd_state_e state_q, state_d;

  logic [NumW-1:0]        speed_const_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic                   timing_q;
  logic                   lane_q;
  logic [SpW-1:0]         speed_q, speed_d;
  logic                   out_valid_q, out_valid_d;
  lgsd_pkg::out_beat_t    out_q;
  lgsd_pkg::out_beat_t    out_beat;

  logic                   in_fire;
  logic                   clear_hit;
  logic                   cnt_zero;
  logic                   out_free;
  logic                   div_start;
  logic                   dig_start;
  logic                   out_load;
  logic                   div_done;
  logic [NumW-1:0]        quotient;
  logic                   dig_done;
  lgsd_pkg::digits_t      digits;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign clear_hit   = in_fire && (in_data_i.op == lgsd_pkg::OP_CLEAR) && timing_q &&
                       (in_data_i.lane == lane_q);
  assign cnt_zero    = (cnt_q == '0);
  assign out_free    = !out_valid_q || !out_stall_i;

  // speed constant register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_const_q <= lgsd_pkg::SPEED_CONSTANT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      speed_const_q <= cfg_data_i;
    end
  end

  // tick counter and lane claim
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      timing_q <= 1'b0;
      lane_q   <= 1'b0;
    end else if (in_fire) begin
      case (in_data_i.op)
        lgsd_pkg::OP_TICK: begin
          if (timing_q && (cnt_q != '1)) begin
            cnt_q <= cnt_q + COUNT_WIDTH'(1);
          end
        end
        lgsd_pkg::OP_BLOCK: begin
          if (!timing_q || (in_data_i.lane == lane_q)) begin
            cnt_q    <= '0;
            timing_q <= 1'b1;
            lane_q   <= in_data_i.lane;
          end
        end
        lgsd_pkg::OP_CLEAR: begin
          if (clear_hit) begin
            timing_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lgsd_pkg::ST_IDLE: begin
        if (clear_hit) begin
          state_d = cnt_zero ? lgsd_pkg::ST_DIGIT : lgsd_pkg::ST_DIV;
        end
      end
      lgsd_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = lgsd_pkg::ST_DIGIT;
        end
      end
      lgsd_pkg::ST_DIGIT: begin
        if (dig_done) begin
          state_d = lgsd_pkg::ST_OUT;
        end
      end
      lgsd_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = lgsd_pkg::ST_IDLE;
        end
      end
      default: state_d = lgsd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    dig_start  = 1'b0;
    out_load   = 1'b0;
    speed_d    = speed_q;
    case (state_q)
      lgsd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (clear_hit) begin
          if (cnt_zero) begin
            dig_start = 1'b1;
            speed_d   = lgsd_pkg::SPEED_MAX;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      lgsd_pkg::ST_DIV: begin
        if (div_done) begin
          dig_start = 1'b1;
          speed_d   = (quotient > {{(NumW-SpW){1'b0}}, lgsd_pkg::SPEED_MAX}) ?
                      lgsd_pkg::SPEED_MAX : quotient[SpW-1:0];
        end
      end
      lgsd_pkg::ST_DIGIT: ;
      lgsd_pkg::ST_OUT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // shared divider
  lgsd_divider #(
    .CountWidth(COUNT_WIDTH)
  ) u_divider (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (div_start),
    .numerator_i  (speed_const_q),
    .denominator_i(cnt_q),
    .done_o       (div_done),
    .quotient_o   (quotient)
  );

  // digit splitter
  lgsd_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dig_start),
    .value_i (speed_d),
    .done_o  (dig_done),
    .digits_o(digits)
  );

  // segment codes for the result beat
  always_comb begin
    out_beat.display_lane = lane_q;
    out_beat.speed_value  = speed_q;
    if (speed_q >= lgsd_pkg::SPEED_HUNDRED) begin
      out_beat.high_segments = lgsd_pkg::seg_of(digits.hundreds);
      out_beat.low_segments  = lgsd_pkg::seg_of(digits.tens);
    end else begin
      out_beat.high_segments = lgsd_pkg::seg_of(digits.tens) | lgsd_pkg::POINT_BIT;
      out_beat.low_segments  = lgsd_pkg::seg_of(digits.ones);
    end
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgsd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    speed_q <= speed_d;
    if (out_load) begin
      out_q <= out_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_clear_stops_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_hit |=> !timing_q)
    else $error("clear edge on claiming lane did not stop timing");

  a_speed_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lgsd_pkg::ST_OUT) |-> (speed_q <= lgsd_pkg::SPEED_MAX))
    else $error("speed value above saturation limit");

  a_tick_no_decrease: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.op == lgsd_pkg::OP_TICK) && timing_q) |=>
      (cnt_q >= $past(cnt_q)))
    else $error("tick counter went backwards");

  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_done |-> ((digits.hundreds <= lgsd_pkg::DIGIT_MAX) &&
                  (digits.tens <= lgsd_pkg::DIGIT_MAX) &&
                  (digits.ones <= lgsd_pkg::DIGIT_MAX)))
    else $error("digit out of decimal range");
`endif

endmodule

`default_nettype wire
